// ===== rtl/ardl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the register-directive lexer: token kinds, token record,
// offset constants and the word classifier. No dependencies.
package ardl_pkg;

  localparam int LINE_SIZE = 256;
  localparam int KW_CHARS  = 9;
  localparam int OFF_W     = 9;
  localparam int START_W   = 8;
  localparam int LEN_W     = 4;
  localparam int LEN_SAT   = 10;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  typedef enum logic [3:0] {
    KIND_AREG      = 4'd0,
    KIND_DREG      = 4'd1,
    KIND_KILL      = 4'd2,
    KIND_RESERVE   = 4'd3,
    KIND_UNRESERVE = 4'd4,
    KIND_REGISTER  = 4'd5,
    KIND_IDENT     = 4'd6,
    KIND_LPAREN    = 4'd7,
    KIND_RPAREN    = 4'd8,
    KIND_PROC      = 4'd9,
    KIND_ENDPROC   = 4'd10,
    KIND_COMMA     = 4'd11,
    KIND_COLON     = 4'd12,
    KIND_EOL       = 4'd13,
    KIND_UNKNOWN   = 4'd14
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [START_W-1:0] start_off;
    logic [OFF_W-1:0]   end_off;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef logic [KW_CHARS-1:0][7:0] word_chars_t;

  // first character sits in the low byte
  localparam word_chars_t KW_AREG      = {40'd0, "gera"};
  localparam word_chars_t KW_DREG      = {40'd0, "gerd"};
  localparam word_chars_t KW_KILL      = {40'd0, "llik"};
  localparam word_chars_t KW_PROC      = {40'd0, "corp"};
  localparam word_chars_t KW_RESERVE   = {16'd0, "evreser"};
  localparam word_chars_t KW_ENDPROC   = {16'd0, "corpdne"};
  localparam word_chars_t KW_UNRESERVE = "evresernu";

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic is_space_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic kw_match(input word_chars_t ch, input logic [LEN_W-1:0] len,
                                    input word_chars_t kw, input logic [LEN_W-1:0] kw_len);
    logic ok;
    ok = (len == kw_len);
    for (int i = 0; i < KW_CHARS; i++) begin
      if (LEN_W'(i) < kw_len && ch[i] != kw[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic tok_kind_e classify_word(input word_chars_t ch,
                                              input logic [LEN_W-1:0] len);
    tok_kind_e k;
    k = KIND_IDENT;
    if (len == LEN_W'(2) && (ch[0] == "a" || ch[0] == "d") &&
        ch[1] >= "0" && ch[1] <= "7") k = KIND_REGISTER;
    if (kw_match(ch, len, KW_DREG, LEN_W'(4)))      k = KIND_DREG;
    if (kw_match(ch, len, KW_AREG, LEN_W'(4)))      k = KIND_AREG;
    if (kw_match(ch, len, KW_KILL, LEN_W'(4)))      k = KIND_KILL;
    if (kw_match(ch, len, KW_PROC, LEN_W'(4)))      k = KIND_PROC;
    if (kw_match(ch, len, KW_RESERVE, LEN_W'(7)))   k = KIND_RESERVE;
    if (kw_match(ch, len, KW_ENDPROC, LEN_W'(7)))   k = KIND_ENDPROC;
    if (kw_match(ch, len, KW_UNRESERVE, LEN_W'(9))) k = KIND_UNRESERVE;
    return k;
  endfunction

endpackage

// ===== rtl/ardl_tok_fifo.sv =====
`timescale 1ns / 1ps
// Small token queue: takes up to two tokens per cycle, gives one per cycle.
// Depends on ardl_pkg.
module ardl_tok_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ardl_pkg::push_t              push_i,
  input  logic                         pop_i,
  output logic [ardl_pkg::Q_CNT_W-1:0] count_o,
  output ardl_pkg::token_t             head_o
);
  import ardl_pkg::*;

  token_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   count_q, count_d;
  logic [Q_PTR_W-1:0]   wr1;

  assign wr1      = wr_ptr_q + Q_PTR_W'(1);
  assign wr_ptr_d = wr_ptr_q + Q_PTR_W'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + Q_PTR_W'(pop_i);
  assign count_d  = count_q + Q_CNT_W'(push_i.cnt) - Q_CNT_W'(pop_i);
  assign count_o  = count_q;
  assign head_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.cnt == 2'd2) mem_q[wr1] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/asm_register_directive_lexer_core.sv =====
`timescale 1ns / 1ps
// Top level of the register-directive lexer: input register, lexer state and
// token building. Depends on ardl_pkg and ardl_tok_fifo.

// One character is taken per cycle unless the input stalls; a token passes
// through the input register and the token queue before it is offered at the
// output. A character that closes a word and is itself a token (punctuation,
// unknown byte or end of line) yields two tokens, and the output port delivers
// at most one token per cycle, so the second token is absorbed by a four-entry
// token queue; the input stalls only when that queue holds more than two tokens.
module asm_register_directive_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  start_offset_o,
  output logic [8:0]  end_offset_o,
  output logic        last_of_run_o
);
  import ardl_pkg::*;

  logic               in_valid_q;
  logic [7:0]         char_q;
  logic [OFF_W-1:0]   line_off_q, line_off_d;
  logic               in_word_q, in_word_d;
  logic [START_W-1:0] word_start_q, word_start_d;
  logic [LEN_W-1:0]   word_len_q, word_len_d;
  word_chars_t        chars_q;
  logic               go;
  logic [Q_CNT_W-1:0] q_count;
  push_t              push;
  token_t             head;
  logic [OFF_W-1:0]   off_inc;
  logic [START_W-1:0] off_start;
  logic               c_word, c_space, c_nul, close_word;
  token_t             word_tok, char_tok;
  tok_kind_e          char_kind;

  assign go         = in_valid_q && (q_count <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_ready_o = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) char_q <= char_code_i;
  end

  assign off_inc   = (line_off_q == OFF_W'(LINE_SIZE)) ? line_off_q : line_off_q + OFF_W'(1);
  assign off_start = (line_off_q > OFF_W'(LINE_SIZE - 1)) ? START_W'(LINE_SIZE - 1)
                                                          : line_off_q[START_W-1:0];
  assign c_word     = is_word_byte(char_q);
  assign c_space    = is_space_byte(char_q);
  assign c_nul      = (char_q == 8'd0);
  assign close_word = in_word_q && !c_word;

  always_comb begin
    case (char_q)
      "(":     char_kind = KIND_LPAREN;
      ")":     char_kind = KIND_RPAREN;
      ",":     char_kind = KIND_COMMA;
      ":":     char_kind = KIND_COLON;
      8'd0:    char_kind = KIND_EOL;
      default: char_kind = KIND_UNKNOWN;
    endcase
  end

  always_comb begin
    word_tok.kind      = classify_word(chars_q, word_len_q);
    word_tok.start_off = word_start_q;
    word_tok.end_off   = line_off_q;
    word_tok.last      = c_word || c_space;
    char_tok.kind      = char_kind;
    char_tok.start_off = off_start;
    char_tok.end_off   = off_inc;
    char_tok.last      = 1'b1;
  end

  always_comb begin
    line_off_d   = line_off_q;
    in_word_d    = in_word_q;
    word_start_d = word_start_q;
    word_len_d   = word_len_q;
    push.cnt     = 2'd0;
    push.tok0    = word_tok;
    push.tok1    = char_tok;
    if (go) begin
      if (in_word_q && c_word) begin
        if (word_len_q < LEN_W'(LEN_SAT)) word_len_d = word_len_q + LEN_W'(1);
        line_off_d = off_inc;
      end else begin
        in_word_d = 1'b0;
        if (c_word) begin
          in_word_d    = 1'b1;
          word_start_d = off_start;
          word_len_d   = LEN_W'(1);
          line_off_d   = off_inc;
        end else if (c_space) begin
          line_off_d = off_inc;
        end else if (c_nul) begin
          line_off_d = '0;
        end else begin
          line_off_d = off_inc;
        end
        if (close_word) begin
          push.cnt = (c_word || c_space) ? 2'd1 : 2'd2;
        end else if (!c_word && !c_space) begin
          push.cnt  = 2'd1;
          push.tok0 = char_tok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_off_q   <= '0;
      in_word_q    <= 1'b0;
      word_start_q <= '0;
      word_len_q   <= '0;
    end else begin
      line_off_q   <= line_off_d;
      in_word_q    <= in_word_d;
      word_start_q <= word_start_d;
      word_len_q   <= word_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && c_word) begin
      if (!in_word_q) begin
        chars_q[0] <= char_q;
      end else if (word_len_q < LEN_W'(KW_CHARS)) begin
        chars_q[word_len_q] <= char_q;
      end
    end
  end

  ardl_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .count_o (q_count),
    .head_o  (head)
  );

  assign out_valid_o    = (q_count != '0);
  assign token_kind_o   = head.kind;
  assign start_offset_o = head.start_off;
  assign end_offset_o   = head.end_off;
  assign last_of_run_o  = head.last;

endmodule

// ===== rtl/ardl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the lexer top level, bound to it below.
// Depends on ardl_pkg.
module ardl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] token_kind_o,
  input logic [7:0] start_offset_o,
  input logic [8:0] end_offset_o,
  input logic       last_of_run_o
);
  import ardl_pkg::*;

  logic one_char;
  assign one_char = token_kind_o == KIND_LPAREN || token_kind_o == KIND_RPAREN ||
                    token_kind_o == KIND_COMMA || token_kind_o == KIND_COLON ||
                    token_kind_o == KIND_EOL || token_kind_o == KIND_UNKNOWN;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(end_offset_o) && $stable(last_of_run_o))
    else $error("token changed while stalled");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, start_offset_o} < end_offset_o)
    else $error("token span empty");

  a_one_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && one_char |-> end_offset_o == {1'b0, start_offset_o} + 9'd1)
    else $error("single-character token span wrong");

  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_EOL |-> last_of_run_o)
    else $error("end-of-line token not last");

endmodule

bind asm_register_directive_lexer_core ardl_checker u_ardl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .start_offset_o (start_offset_o),
  .end_offset_o   (end_offset_o),
  .last_of_run_o  (last_of_run_o)
);

// ===== test/asm_register_directive_lexer_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for asm_register_directive_lexer_core: feeds source bytes, predicts
// the token stream in its own lexer copy and checks every token transfer.
// Depends on ardl_pkg and the lexer RTL.
module asm_register_directive_lexer_core_tb;
  import ardl_pkg::*;

  localparam int LIMIT_CYCLES = 600000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] token_kind_o;
  logic [7:0] start_offset_o;
  logic [8:0] end_offset_o;
  logic       last_of_run_o;

  asm_register_directive_lexer_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  // lexer copy
  int unsigned line_pos   = 0;
  bit          word_open  = 1'b0;
  int unsigned word_begin = 0;
  int unsigned word_len   = 0;
  logic [7:0]  word_buf [KW_CHARS];

  token_t      expected_tokens [$];
  int unsigned errs = 0;
  int unsigned chars_sent = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;
  int unsigned hold_req = 0;

  logic [7:0]  line_buf [$];
  string       kw_names [7] = '{"dreg", "areg", "kill", "reserve", "unreserve", "proc",
                                "endproc"};

  function automatic bit ident_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic tok_kind_e word_kind();
    logic [71:0] w;
    w = '0;
    if (word_len <= KW_CHARS) begin
      for (int i = 0; i < word_len; i++) w = {w[63:0], word_buf[i]};
      case (word_len)
        4: begin
          if (w == "dreg") return KIND_DREG;
          if (w == "areg") return KIND_AREG;
          if (w == "kill") return KIND_KILL;
          if (w == "proc") return KIND_PROC;
        end
        7: begin
          if (w == "reserve") return KIND_RESERVE;
          if (w == "endproc") return KIND_ENDPROC;
        end
        9: if (w == "unreserve") return KIND_UNRESERVE;
        default: ;
      endcase
    end
    if (word_len == 2 && (word_buf[0] == "a" || word_buf[0] == "d") &&
        word_buf[1] >= "0" && word_buf[1] <= "7") return KIND_REGISTER;
    return KIND_IDENT;
  endfunction

  function automatic token_t make_tok(tok_kind_e k, int unsigned s, int unsigned e);
    token_t t;
    t.kind      = k;
    t.start_off = START_W'((s > LINE_SIZE - 1) ? LINE_SIZE - 1 : s);
    t.end_off   = OFF_W'((e > LINE_SIZE) ? LINE_SIZE : e);
    t.last      = 1'b0;
    return t;
  endfunction

  function automatic int unsigned next_pos(int unsigned p);
    return (p + 1 > LINE_SIZE) ? LINE_SIZE : p + 1;
  endfunction

  task automatic lex_char(logic [7:0] c);
    token_t    toks [2];
    int        n;
    tok_kind_e k;
    n = 0;
    if (word_open) begin
      if (ident_char(c)) begin
        if (word_len < KW_CHARS) word_buf[word_len] = c;
        if (word_len < LEN_SAT) word_len++;
        line_pos = next_pos(line_pos);
        return;
      end
      toks[n] = make_tok(word_kind(), word_begin, line_pos);
      n = n + 1;
      word_open = 1'b0;
    end
    if (ident_char(c)) begin
      word_open   = 1'b1;
      word_begin  = (line_pos > LINE_SIZE - 1) ? LINE_SIZE - 1 : line_pos;
      word_buf[0] = c;
      word_len    = 1;
      line_pos    = next_pos(line_pos);
    end else if (blank_char(c)) begin
      line_pos = next_pos(line_pos);
    end else if (c == 8'd0) begin
      toks[n] = make_tok(KIND_EOL, line_pos, line_pos + 1);
      n = n + 1;
      line_pos  = 0;
    end else begin
      case (c)
        "(":     k = KIND_LPAREN;
        ")":     k = KIND_RPAREN;
        ",":     k = KIND_COMMA;
        ":":     k = KIND_COLON;
        default: k = KIND_UNKNOWN;
      endcase
      toks[n] = make_tok(k, line_pos, line_pos + 1);
      n = n + 1;
      line_pos  = next_pos(line_pos);
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) toks[i].last = 1'b1;
      expected_tokens.push_back(toks[i]);
    end
  endtask

  // token check
  always @(posedge clk_i) begin
    token_t t;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token transfer: token_kind %0d", token_kind_o);
        errs++;
      end else begin
        t = expected_tokens.pop_front();
        if (token_kind_o !== t.kind) begin
          $error("token_kind expected %0d actual %0d", t.kind, token_kind_o);
          errs++;
        end
        if (start_offset_o !== t.start_off) begin
          $error("start_offset expected %0d actual %0d", t.start_off, start_offset_o);
          errs++;
        end
        if (end_offset_o !== t.end_off) begin
          $error("end_offset expected %0d actual %0d", t.end_off, end_offset_o);
          errs++;
        end
        if (last_of_run_o !== t.last) begin
          $error("last_of_run expected %0d actual %0d", t.last, last_of_run_o);
          errs++;
        end
      end
    end
  end

  // receiver: random stalls, forced hold when requested
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        out_ready_i <= 1'b0;
        hold_req--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle) begin
          r = $urandom_range(0, 99);
          if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 23) stall_left = $urandom_range(8, 20);
          else if (r < 25) stall_left = $urandom_range(30, 60);
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_char(logic [7:0] c);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    lex_char(c);
    chars_sent++;
  endtask

  task automatic wait_idle(int unsigned tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_blank();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       line_buf.push_back(8'h09);
      1:       line_buf.push_back(8'h0A);
      2:       line_buf.push_back(8'h0B);
      3:       line_buf.push_back(8'h0C);
      4:       line_buf.push_back(8'h0D);
      default: line_buf.push_back(8'h20);
    endcase
  endtask

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  task automatic put_word();
    int unsigned r;
    int unsigned n;
    int unsigned pos0;
    string       kw;
    r = $urandom_range(0, 99);
    pos0 = line_buf.size();
    if (r < 40) begin
      put_str(kw_names[$urandom_range(0, 6)]);
    end else if (r < 62) begin
      line_buf.push_back(($urandom_range(0, 1) != 0) ? "a" : "d");
      line_buf.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) line_buf[pos0] = line_buf[pos0] ^ 8'h20;
    end else if (r < 75) begin
      // near miss of a keyword: case flip, cut or extension
      kw = kw_names[$urandom_range(0, 6)];
      put_str(kw);
      case ($urandom_range(0, 2))
        0: begin
          n = pos0 + $urandom_range(0, kw.len() - 1);
          line_buf[n] = line_buf[n] ^ 8'h20;
        end
        1:       void'(line_buf.pop_back());
        default: line_buf.push_back(rand_word_char());
      endcase
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
      repeat (n) line_buf.push_back(rand_word_char());
    end
  endtask

  task automatic put_directive_line();
    int unsigned ops;
    repeat ($urandom_range(0, 2)) put_blank();
    if ($urandom_range(0, 4) == 0) begin
      put_word();
      line_buf.push_back(":");
      put_blank();
    end
    put_word();
    ops = $urandom_range(0, 4);
    for (int i = 0; i < ops; i++) begin
      if (i == 0 || $urandom_range(0, 2) == 0) put_blank();
      if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back("(");
        put_word();
        line_buf.push_back(")");
      end else begin
        put_word();
      end
      if (i != ops - 1) line_buf.push_back(($urandom_range(0, 5) == 0) ? ":" : ",");
      if ($urandom_range(0, 19) == 0) line_buf.push_back(8'($urandom_range(1, 255)));
    end
    repeat ($urandom_range(0, 1)) put_blank();
    line_buf.push_back(8'd0);
  endtask

  task automatic put_noise_line();
    repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
    line_buf.push_back(8'd0);
  endtask

  task automatic test_delimiters();
    put_str("areg d7(x),:");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h08);
    line_buf.push_back(8'h0E);
    line_buf.push_back(8'h0B);
    line_buf.push_back(8'h0D);
    put_str("_Z9");
    line_buf.push_back(8'd0);
    line_buf.push_back(8'd0);
    send_line();
    wait_idle(10);
  endtask

  task automatic test_keywords();
    put_str("dreg proc\tendproc(reserve)unreserve,kill:a0 D1 d8");
    line_buf.push_back(8'h7F);
    line_buf.push_back(8'd0);
    send_line();
    wait_idle(10);
  endtask

  task automatic test_long_words();
    put_str("unreserved unreservE abcdefghijklmno:unreserve_x");
    line_buf.push_back(8'd0);
    send_line();
    wait_idle(10);
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    no_idle  = 1'b1;
    repeat (25) put_str("d3,");
    line_buf.push_back(8'd0);
    send_line();
    no_idle = 1'b0;
    wait_idle(10);
  endtask

  task automatic test_random_lines();
    int unsigned stop_at;
    stop_at = chars_sent + 270;
    while (chars_sent < stop_at) begin
      no_idle = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 99) < 75) put_directive_line();
      else put_noise_line();
      send_line();
    end
    no_idle = 1'b0;
    wait_idle(10);
  endtask

  task automatic test_saturation();
    repeat (250) put_blank();
    put_str("reserve(d2");
    send_line();
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) line_buf.push_back(rand_word_char());
      else put_blank();
    end
    put_str("kill,a1:");
    line_buf.push_back(8'd0);
    put_str("proc");
    line_buf.push_back(8'd0);
    send_line();
    wait_idle(10);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_delimiters();
    test_keywords();
    test_long_words();
    test_backpressure();
    test_random_lines();
    test_saturation();
    wait_idle(50);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      errs++;
    end
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ardl_pkg.sv
rtl/ardl_tok_fifo.sv
rtl/asm_register_directive_lexer_core.sv
rtl/ardl_checker.sv
test/asm_register_directive_lexer_core_tb.sv
